/* sv/lzwh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwh_pkg
// Shared constants, command and status types of the LZW hash encoder.
// ----------------------------------------------------------------------------
package lzwh_pkg;

   localparam int TABLE_ENTRIES = 5021;
   localparam int CODE_BITS     = 12;
   localparam int HASH_SHIFT    = 4;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int HASH_W  = (8 + HASH_SHIFT > CODE_BITS) ? 8 + HASH_SHIFT : CODE_BITS;
   localparam int TAG_W   = 4;
   localparam int ACC_W   = CODE_BITS + 7;
   localparam int CNT_W   = $clog2(ACC_W + 1);
   localparam int ENTRY_W = TAG_W + 2 * CODE_BITS + 8;

   localparam logic [IDX_W-1:0]     LAST_SLOT    = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W:0]       TE_EXT       = (IDX_W+1)'(TABLE_ENTRIES);
   localparam logic [CODE_BITS-1:0] FIRST_CODE   = CODE_BITS'(256);
   localparam logic [CODE_BITS-1:0] END_CODE     = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-1:0] LAST_ADDABLE = END_CODE - CODE_BITS'(1);
   localparam logic [TAG_W-1:0]     TAG_MAX      = {TAG_W{1'b1}};
   localparam logic [15:0]          MAX_OUT_RST  = 16'd2048;

   // code select for loading the packer
   localparam logic [1:0] SEL_CUR  = 2'd0;
   localparam logic [1:0] SEL_END  = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;

   typedef struct packed {
      logic       accept;     // latch input item
      logic       start_pkt;  // first byte of a packet
      logic       clr_step;   // write empty tag at sweep address
      logic       home;       // set probe index to home slot
      logic       rd;         // read table at probe index
      logic       miss_step;  // advance probe
      logic       hit;        // current string takes matched code
      logic       add;        // write new dictionary entry
      logic       cur_ch;     // current string becomes latched byte
      logic       load;       // load a code into the packer
      logic [1:0] load_sel;
      logic       put;        // shift one byte out of the packer
      logic       drain_end;  // keep leftover bits
      logic       finish;     // close the item
   } lzwh_cmd_type;

   typedef struct packed {
      logic first;
      logic dropping;
      logic last;
      logic tag_full;
      logic clr_done;
      logic used;
      logic match;
      logic probe_full;
      logic can_add;
      logic cnt_ge8;
      logic aborted;
      logic can_put;
      logic can_finish;
   } lzwh_sts_type;

endpackage

/* sv/lzwh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwh_ctrl
// Sequencer: table sweep, probe, packing and end-of-packet steps for one item at a time.
// ----------------------------------------------------------------------------
module lzwh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   output lzwh_pkg::lzwh_cmd_type cmd,
   input  lzwh_pkg::lzwh_sts_type sts
);
   import lzwh_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_PRD   = 3'd2;
   localparam logic [2:0] ST_PCMP  = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_TAIL  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;   // tail codes already loaded

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               phase_in   = 2'd0;
               if (sts.first) begin
                  cmd.start_pkt = 1'b1;
                  if (sts.tag_full) state_in = ST_CLEAR;
                  else state_in = req_tlast ? ST_TAIL : ST_FIN;
               end else if (sts.dropping) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.home = 1'b1;
                  state_in = ST_PRD;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = sts.last ? ST_TAIL : ST_FIN;
         end
         ST_PRD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            if (sts.used && sts.match) begin
               cmd.hit  = 1'b1;
               state_in = sts.last ? ST_TAIL : ST_FIN;
            end else if (!sts.used || sts.probe_full) begin
               cmd.add      = !sts.used && sts.can_add;
               cmd.load     = 1'b1;
               cmd.load_sel = SEL_CUR;
               cmd.cur_ch   = 1'b1;
               state_in     = ST_SHIFT;
            end else begin
               cmd.miss_step = 1'b1;
               state_in      = ST_PRD;
            end
         end
         ST_SHIFT: begin
            if (sts.aborted) begin
               state_in = ST_FIN;
            end else if (sts.cnt_ge8) begin
               cmd.put = sts.can_put;
            end else begin
               cmd.drain_end = 1'b1;
               state_in = (sts.last && phase_ff != 2'd3) ? ST_TAIL : ST_FIN;
            end
         end
         ST_TAIL: begin
            if (sts.aborted) begin
               state_in = ST_FIN;
            end else begin
               cmd.load = 1'b1;
               unique case (phase_ff)
                  2'd0:    cmd.load_sel = SEL_CUR;
                  2'd1:    cmd.load_sel = SEL_END;
                  default: cmd.load_sel = SEL_ZERO;
               endcase
               phase_in = phase_ff + 2'd1;
               state_in = ST_SHIFT;
            end
         end
         ST_FIN: begin
            if (sts.can_finish) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/lzwh_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwh_datapath
// Hash table memory, probe arithmetic, code packer and output register.
// ----------------------------------------------------------------------------
module lzwh_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  lzwh_pkg::lzwh_cmd_type cmd,
   output lzwh_pkg::lzwh_sts_type sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic [1:0]             rsp_tuser
);
   import lzwh_pkg::*;

   // table entry: {tag, code, prefix, char}
   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_ff;

   logic [7:0]           ch_ff;
   logic                 last_ff;
   logic                 started_ff, dropping_ff, aborted_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [IDX_W-1:0]     clr_ff, idx_ff, off_ff, n_ff;
   logic [CODE_BITS-1:0] cur_ff, nfc_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [6:0]           pb_ff;
   logic [2:0]           pc_ff;
   logic [15:0]          bs_ff, max_ff;
   logic                 stg_valid_ff, stg_ovf_ff;
   logic [7:0]           stg_byte_ff;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [7:0]           rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   logic [TAG_W-1:0]     rd_tag;
   logic [CODE_BITS-1:0] rd_code, rd_prefix;
   logic [7:0]           rd_char;
   assign {rd_tag, rd_code, rd_prefix, rd_char} = rd_ff;

   // home slot and probe step
   logic [HASH_W-1:0] hraw;
   logic [IDX_W:0]    hext;
   logic [IDX_W-1:0]  home, home_off, step_idx;
   logic [IDX_W:0]    idx_wrap;
   always_comb begin
      hraw     = (HASH_W'(in_byte) << HASH_SHIFT) ^ HASH_W'(cur_ff);
      hext     = (IDX_W+1)'(hraw);
      if (hext >= TE_EXT) hext = hext - TE_EXT;
      home     = hext[IDX_W-1:0];
      home_off = (home == '0) ? IDX_W'(1) : IDX_W'(TE_EXT - hext);
      idx_wrap = {1'b0, idx_ff} + TE_EXT - {1'b0, off_ff};
      step_idx = (idx_ff >= off_ff) ? (idx_ff - off_ff) : idx_wrap[IDX_W-1:0];
   end

   // packer
   logic [CNT_W-1:0] sh;
   logic [ACC_W-1:0] acc_sh, acc_mask;
   logic [7:0]       out_b;
   logic [15:0]      bs_inc;
   logic             ovf;
   logic             out_free;
   logic [CODE_BITS-1:0] load_code;
   always_comb begin
      sh       = cnt_ff - CNT_W'(8);
      acc_sh   = acc_ff >> sh;
      out_b    = acc_sh[7:0];
      acc_mask = (ACC_W'(1) << sh) - ACC_W'(1);
      bs_inc   = bs_ff + 16'd1;
      ovf      = (bs_inc >= max_ff);
      out_free = !rsp_valid_ff || rsp_tready;
      unique case (cmd.load_sel)
         SEL_CUR:  load_code = cur_ff;
         SEL_END:  load_code = END_CODE;
         default:  load_code = '0;
      endcase
   end

   always_comb begin
      sts.first      = !started_ff;
      sts.dropping   = dropping_ff;
      sts.last       = last_ff;
      sts.tag_full   = (tag_ff == TAG_MAX);
      sts.clr_done   = (clr_ff == LAST_SLOT);
      sts.used       = (rd_tag == tag_ff);
      sts.match      = (rd_prefix == cur_ff) && (rd_char == ch_ff);
      sts.probe_full = (n_ff == LAST_SLOT);
      sts.can_add    = (nfc_ff <= LAST_ADDABLE);
      sts.cnt_ge8    = (cnt_ff >= CNT_W'(8));
      sts.aborted    = aborted_ff;
      sts.can_put    = !stg_valid_ff || out_free;
      sts.can_finish = !stg_valid_ff || out_free;
   end

   // single-port table
   logic [IDX_W-1:0]   maddr;
   logic               mwe;
   logic [ENTRY_W-1:0] mwdata;
   always_comb begin
      maddr  = cmd.clr_step ? clr_ff : idx_ff;
      mwe    = cmd.clr_step || cmd.add;
      mwdata = cmd.clr_step ? '0 : {tag_ff, nfc_ff, cur_ff, ch_ff};
   end

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwdata;
      if (cmd.rd) rd_ff <= mem[maddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff   <= in_byte;
         last_ff <= in_last;
      end
      if (cmd.start_pkt) begin
         clr_ff <= '0;
         cur_ff <= CODE_BITS'(in_byte);
         nfc_ff <= FIRST_CODE;
         bs_ff  <= '0;
      end
      if (cmd.clr_step) clr_ff <= clr_ff + IDX_W'(1);
      if (cmd.home) begin
         idx_ff <= home;
         off_ff <= home_off;
         n_ff   <= '0;
      end
      if (cmd.miss_step) begin
         idx_ff <= step_idx;
         n_ff   <= n_ff + IDX_W'(1);
      end
      if (cmd.hit) cur_ff <= rd_code;
      if (cmd.add) nfc_ff <= nfc_ff + CODE_BITS'(1);
      if (cmd.cur_ch) cur_ff <= CODE_BITS'(ch_ff);
      if (cmd.load) begin
         acc_ff <= {pb_ff, load_code};
         cnt_ff <= CNT_W'(pc_ff) + CNT_W'(CODE_BITS);
      end
      if (cmd.put) begin
         acc_ff      <= acc_ff & acc_mask;
         cnt_ff      <= sh;
         bs_ff       <= bs_inc;
         stg_byte_ff <= out_b;
         stg_ovf_ff  <= ovf;
      end
      if (cmd.put && stg_valid_ff) begin
         rsp_data_ff <= stg_byte_ff;
         rsp_last_ff <= 1'b0;
         rsp_user_ff <= {stg_ovf_ff, 1'b0};
      end else if (cmd.finish && stg_valid_ff) begin
         rsp_data_ff <= stg_byte_ff;
         rsp_last_ff <= 1'b1;
         rsp_user_ff <= {stg_ovf_ff, last_ff && !aborted_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         dropping_ff  <= 1'b0;
         aborted_ff   <= 1'b0;
         tag_ff       <= TAG_MAX;
         pb_ff        <= '0;
         pc_ff        <= '0;
         max_ff       <= MAX_OUT_RST;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         if (cmd.accept) aborted_ff <= 1'b0;
         if (cmd.start_pkt) begin
            started_ff  <= 1'b1;
            dropping_ff <= 1'b0;
            pb_ff       <= '0;
            pc_ff       <= '0;
            tag_ff      <= (tag_ff == TAG_MAX) ? TAG_W'(1) : tag_ff + TAG_W'(1);
         end
         if (cmd.put) begin
            stg_valid_ff <= 1'b1;
            if (ovf) aborted_ff <= 1'b1;
         end
         if (cmd.drain_end) begin
            pb_ff <= acc_ff[6:0];
            pc_ff <= cnt_ff[2:0];
         end
         if (cmd.finish) begin
            stg_valid_ff <= 1'b0;
            if (aborted_ff) dropping_ff <= 1'b1;
            if (last_ff) begin
               started_ff  <= 1'b0;
               dropping_ff <= 1'b0;
               pb_ff       <= '0;
               pc_ff       <= '0;
            end
         end
         if ((cmd.put || cmd.finish) && stg_valid_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* sv/lzw_hash_encoder.sv */
`timescale 1ns / 1ps
// Per byte: an accept step, then per hash probe a table read and a compare, then per
//   output byte a shift, a step that keeps the leftover bits of each emitted code and
//   a finish step; the first byte of a packet takes no probe.
// One item at a time, probes bounded by the single-port table (a read, then a compare).
// Every 15th packet start sweeps all 5021 table slots, with no input taken meanwhile.
// Reset: synchronous, active high; clears control state, limit returns to 2048.
// ----------------------------------------------------------------------------
// lzw_hash_encoder
// Packet-wise LZW compressor, fixed 12-bit codes, MSB-first byte packing.
// ----------------------------------------------------------------------------
module lzw_hash_encoder (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser,   // [0] packet_end, [1] overflow
   // max_output_bytes register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import lzwh_pkg::*;

   lzwh_cmd_type cmd;
   lzwh_sts_type sts;

   // Dictionary slots carry a 4-bit packet tag; a slot is in use only when its
   // tag matches the current packet, so no per-packet clear is needed. When the
   // tag wraps, the controller sweeps all slots back to tag zero.
   lzwh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // One output byte is held back in a staging register until the next byte
   // or the end of the item shows whether it is the last transfer of the item.
   lzwh_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* sv/lzwh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwh_checker
// Port-level checks of the result stream flags and of valid hold under stall.
// ----------------------------------------------------------------------------
module lzwh_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("packet end not on last transfer of item");

   a_ovf_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("overflow byte not last of item");

   a_end_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("packet end and overflow together");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

endmodule

bind lzw_hash_encoder lzwh_checker u_lzwh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZW hash encoder: packets of bytes go in as
// transfers, an in-bench LZW model predicts every compressed byte and its
// flags, and the monitor compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
   import lzwh_pkg::*;

   localparam int NSLOT = TABLE_ENTRIES;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       pkt_end;
      logic       ovf;
   } comp_byte_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   lzw_hash_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .req_tlast  (req_tlast),   // last_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tlast  (rsp_tlast),   // run_last
      .rsp_tuser  (rsp_tuser),   // [0] packet_end, [1] overflow
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // LZW model state
   // ---------------------------------------------------------------------
   bit                   dict_used [NSLOT];
   logic [CODE_BITS-1:0] dict_code [NSLOT];
   logic [CODE_BITS-1:0] dict_pfx  [NSLOT];
   logic [7:0]           dict_ch   [NSLOT];
   logic [CODE_BITS-1:0] free_code, cur_str;
   bit                   in_packet, discarding, aborted;
   logic [6:0]           hold_bits;
   int unsigned          hold_cnt;
   logic [15:0]          out_count, out_limit;

   comp_byte_type expected_q[$];
   comp_byte_type item_out[$];
   byte_item_type pending_q[$];

   int errors;
   int mismatches;
   bit tail_calm;       // no idling near the end

   // emit one packed byte; flags overflow when the limit is reached
   task automatic put_out(input logic [7:0] b);
      comp_byte_type r;
      r = '{data: b, run_last: 1'b0, pkt_end: 1'b0, ovf: 1'b0};
      out_count = out_count + 16'd1;
      if (out_count >= out_limit) begin
         r.ovf = 1'b1;
         aborted = 1'b1;
      end
      item_out.push_back(r);
   endtask

   // append one code MSB-first to the bit packer
   task automatic pack_code(input logic [CODE_BITS-1:0] code);
      logic [31:0] acc;
      int unsigned cnt;
      if (aborted) return;
      acc = ({25'd0, hold_bits} << CODE_BITS) | code;
      cnt = hold_cnt + CODE_BITS;
      while (cnt >= 8) begin
         cnt -= 8;
         put_out(8'(acc >> cnt));
         acc &= (32'd1 << cnt) - 1;
         if (aborted) break;
      end
      hold_bits = acc[6:0];
      hold_cnt  = cnt & 7;
   endtask

   // hash lookup: 1 hit, 0 free slot, -1 table exhausted
   function automatic int lookup(input logic [CODE_BITS-1:0] pfx, input logic [7:0] ch,
                                 output int slot);
      int unsigned idx, stride;
      idx = ((int'(ch) << HASH_SHIFT) ^ int'(pfx)) % NSLOT;
      stride = (idx == 0) ? 1 : NSLOT - idx;
      slot = 0;
      for (int n = 0; n < NSLOT; n++) begin
         if (!dict_used[idx]) begin
            slot = idx;
            return 0;
         end
         if (dict_pfx[idx] == pfx && dict_ch[idx] == ch) begin
            slot = idx;
            return 1;
         end
         idx = (idx >= stride) ? idx - stride : idx + NSLOT - stride;
      end
      return -1;
   endfunction

   // compress one input byte, queue its output bytes
   task automatic compress_byte(input byte_item_type it);
      int slot, found;
      item_out.delete();
      aborted = 1'b0;
      if (!in_packet) begin
         foreach (dict_used[i]) dict_used[i] = 1'b0;
         free_code  = FIRST_CODE;
         hold_bits  = '0;
         hold_cnt   = 0;
         out_count  = '0;
         discarding = 1'b0;
         cur_str    = {4'd0, it.data};
         in_packet  = 1'b1;
      end else if (!discarding) begin
         found = lookup(cur_str, it.data, slot);
         if (found == 1) begin
            cur_str = dict_code[slot];
         end else begin
            if (found == 0 && free_code <= LAST_ADDABLE) begin
               dict_used[slot] = 1'b1;
               dict_code[slot] = free_code;
               dict_pfx[slot]  = cur_str;
               dict_ch[slot]   = it.data;
               free_code = free_code + 1'b1;
            end
            pack_code(cur_str);
            cur_str = {4'd0, it.data};
         end
      end
      // end of packet: pending string, end marker, flush code
      if (it.last && !discarding && !aborted) begin
         pack_code(cur_str);
         pack_code(END_CODE);
         pack_code('0);
         if (!aborted && item_out.size() > 0) item_out[item_out.size()-1].pkt_end = 1'b1;
      end
      if (aborted) discarding = 1'b1;
      if (it.last) begin
         in_packet  = 1'b0;
         discarding = 1'b0;
         hold_bits  = '0;
         hold_cnt   = 0;
      end
      if (item_out.size() > 0) item_out[item_out.size()-1].run_last = 1'b1;
      foreach (item_out[i]) expected_q.push_back(item_out[i]);
   endtask

   // ---------------------------------------------------------------------
   // Driver: one transfer per handshake, random idle bursts
   // ---------------------------------------------------------------------
   int src_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            compress_byte(pending_q.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_q[0].data;
               req_tlast  <= pending_q[0].last;
               if (!tail_calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest prediction
   // ---------------------------------------------------------------------
   int sink_gap;
   always @(posedge clock) begin
      comp_byte_type exp_r, got_r;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r = '{data: rsp_tdata, run_last: rsp_tlast, pkt_end: rsp_tuser[0],
                      ovf: rsp_tuser[1]};
            if (expected_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10)
                  $display("unexpected result transfer: %h", got_r);
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r !== got_r) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: exp byte %h last %b end %b ovf %b, got %h %b %b %b",
                              exp_r.data, exp_r.run_last, exp_r.pkt_end, exp_r.ovf,
                              got_r.data, got_r.run_last, got_r.pkt_end, got_r.ovf);
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!tail_calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
         end
      end
   end

   // cycle limit: table sweeps plus stalled results, with a wide margin
   int cycles;
   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_packet(input int len, input int alpha);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1));
         it.last = (i == len - 1);
         pending_q.push_back(it);
      end
   endtask

   task automatic drain_and_wait();
      while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      out_limit = v;
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0; csr_wr_en = 1'b0; csr_wr_data = '0;
      errors = 0; mismatches = 0; cycles = 0; tail_calm = 1'b0;
      in_packet = 1'b0; discarding = 1'b0; out_limit = MAX_OUT_RST;
      free_code = FIRST_CODE; cur_str = '0; hold_bits = '0; hold_cnt = 0; out_count = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-byte packets at the byte extremes, repeats, bytes 0x55 xor index
      pending_q.push_back('{data: 8'h00, last: 1'b1});
      pending_q.push_back('{data: 8'hFF, last: 1'b1});
      for (int i = 0; i < 8; i++) pending_q.push_back('{data: 8'hAA, last: i == 7});
      for (int i = 0; i < 6; i++) pending_q.push_back('{data: 8'h55 ^ 8'(i), last: i == 5});
      drain_and_wait();

      // tight limits: overflow on the first byte, then a few bytes in
      write_limit(16'd1);
      add_packet(5, 4);
      add_packet(1, 256);
      drain_and_wait();
      write_limit(16'd0);
      add_packet(3, 256);
      drain_and_wait();
      write_limit(16'd7);
      add_packet(20, 256);
      add_packet(12, 2);
      drain_and_wait();
      write_limit(16'hFFFF);
      add_packet(40, 3);
      drain_and_wait();

      // random packets under random limits
      sent = 0;
      while (sent < 330) begin
         int len;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
         case ($urandom_range(0, 3))
            0: add_packet(len, 256);
            1: add_packet(len, 2);
            default: add_packet(len, $urandom_range(2, 16));
         endcase
         sent += len;
         if ($urandom_range(0, 7) == 0) begin
            drain_and_wait();
            write_limit(($urandom_range(0, 1) == 1) ? 16'($urandom_range(2, 24))
                                                    : 16'($urandom));
         end
         if (sent > 270) tail_calm = 1'b1;
      end

      drain_and_wait();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
